FILE: sv/tsm_pkg.sv
// Package with opcodes, error codes, result kinds, sequencer states and ALU controls for the stack executor.
package tsm_pkg;

    localparam int unsigned STACK_DEPTH_DEF  = 64;
    localparam int unsigned ADDRESS_BITS_DEF = 16;
    localparam int unsigned VALUE_BITS       = 64;
    localparam int unsigned MODE_BITS        = 5;
    localparam int unsigned DEPTH_BITS       = 7;
    localparam int unsigned NEXT_ADDR_BITS   = 16;

    typedef enum logic [4:0] {
        OP_INVALID  = 5'd0,
        OP_EXIT     = 5'd1,
        OP_JUMP     = 5'd2,
        OP_JUMPF    = 5'd3,
        OP_IPUSH    = 5'd4,
        OP_IDUP     = 5'd5,
        OP_IDROP    = 5'd6,
        OP_ADD      = 5'd7,
        OP_SUB      = 5'd8,
        OP_MUL      = 5'd9,
        OP_DIV      = 5'd10,
        OP_MOD      = 5'd11,
        OP_LT       = 5'd12,
        OP_GT       = 5'd13,
        OP_IEQ      = 5'd14,
        OP_IPRINT   = 5'd15,
        OP_BPUSH    = 5'd16,
        OP_BDUP     = 5'd17,
        OP_BDROP    = 5'd18,
        OP_NOT      = 5'd19,
        OP_BEQ      = 5'd20,
        OP_BPRINT   = 5'd21
    } opcode_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_INVALID   = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_TAG       = 3'd4,
        ERR_DIVZERO   = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        KIND_STEP  = 2'd0,
        KIND_PRINT = 2'd1,
        KIND_FINAL = 2'd2,
        KIND_EMPTY = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TOP,
        ST_RD_WAIT,
        ST_RD_SEC,
        ST_EXEC,
        ST_ALU_WAIT,
        ST_WRITE,
        ST_OUT,
        ST_DUMP_RD,
        ST_DUMP_WAIT,
        ST_DUMP_OUT
    } state_t;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_MOD  = 2'd2
    } alu_op_t;

    // Start request and status of the iterative multiply/divide unit.
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_sts_t;

endpackage

FILE: sv/tsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tsm_ram #(
    parameter int unsigned WIDTH = 65,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: sv/tsm_alu.sv
// Iterative multiply and divide unit, one bit per cycle.
module tsm_alu
    import tsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  alu_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output alu_sts_t              sts,
    output logic [VALUE_BITS-1:0] result
);
    localparam int unsigned CNT_BITS = $clog2(VALUE_BITS) + 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    alu_op_t               op_reg, op_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;     // product or remainder
    logic [VALUE_BITS-1:0] sh_reg, sh_next;       // multiplicand or dividend/quotient
    logic [VALUE_BITS-1:0] op_b_reg, op_b_next;   // multiplier or divisor magnitude
    logic                  neg_q_reg, neg_q_next;
    logic                  neg_r_reg, neg_r_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS-1:0] rem_sh;
    logic [VALUE_BITS-1:0] mag_a, mag_b;

    assign mag_a = a[VALUE_BITS-1] ? (~a + 1'b1) : a;
    assign mag_b = b[VALUE_BITS-1] ? (~b + 1'b1) : b;
    assign rem_sh = {acc_reg[VALUE_BITS-2:0], sh_reg[VALUE_BITS-1]};
    assign trial  = {acc_reg[VALUE_BITS-1], rem_sh} - {1'b0, op_b_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        op_b_next  = op_b_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (ctl.start && !busy_reg) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_BITS'(VALUE_BITS);
            op_next    = ctl.op;
            acc_next   = '0;
            neg_q_next = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
            neg_r_next = a[VALUE_BITS-1];
            if (ctl.op == ALU_MUL) begin
                sh_next   = a;
                op_b_next = b;
            end else begin
                sh_next   = mag_a;
                op_b_next = mag_b;
            end
        end else if (busy_reg) begin
            if (op_reg == ALU_MUL) begin
                if (op_b_reg[0]) begin
                    acc_next = acc_reg + sh_reg;
                end
                sh_next   = {sh_reg[VALUE_BITS-2:0], 1'b0};
                op_b_next = {1'b0, op_b_reg[VALUE_BITS-1:1]};
            end else begin
                // Restoring division step; the top remainder bit may carry out.
                if (!trial[VALUE_BITS]) begin
                    acc_next = trial[VALUE_BITS-1:0];
                    sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b1};
                end else begin
                    acc_next = rem_sh;
                    sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        sh_reg    <= sh_next;
        op_b_reg  <= op_b_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    always_comb begin
        unique case (op_reg)
            ALU_MUL: result = acc_reg;
            ALU_DIV: result = neg_q_reg ? (~sh_reg + 1'b1) : sh_reg;
            default: result = neg_r_reg ? (~acc_reg + 1'b1) : acc_reg;
        endcase
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
endmodule

FILE: sv/typed_stack_machine_executor.sv
// Flow: accept, read top entry, read second entry for two-operand ops, execute, result beat;
// a halted step or an exit on an empty stack goes from the top read straight to its beat.
// Multiply, divide and modulus wait in the shift-add unit, then write back to the stack.
// Throughput: one instruction at a time, held by any output stall; exit streams one beat
// per stack entry, bottom first. Reset (aresetn low, synchronous) clears stack pointer,
// instruction pointer, halt and error; only stack entries below the pointer are used.
module typed_stack_machine_executor
    import tsm_pkg::*;
#(
    parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] immediate
    input  logic [4:0]  s_tuser,   // [4:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [63:0] out_value, [79:64] next_address,
                                   // [86:80] stack_depth, [89:87] error_code, [90] halted
    output logic [2:0]  m_tuser,   // [1:0] out_kind, [2] value_is_bool
    output logic        m_tlast
);
    localparam int unsigned PTR_BITS = $clog2(STACK_DEPTH);
    localparam int unsigned SP_BITS  = $clog2(STACK_DEPTH + 1);

    state_t                  state_reg, state_next;
    logic [SP_BITS-1:0]      sp_reg, sp_next;
    logic [ADDRESS_BITS-1:0] ip_reg, ip_next;
    logic                    stop_reg, stop_next;
    err_t                    err_reg, err_next;
    opcode_t                 op_reg, op_next;
    logic [VALUE_BITS-1:0]   imm_reg, imm_next;
    logic [VALUE_BITS-1:0]   b_reg, b_next;
    logic                    btag_reg, btag_next;
    logic [VALUE_BITS-1:0]   a_reg, a_next;
    logic                    atag_reg, atag_next;
    logic [SP_BITS-1:0]      idx_reg, idx_next;
    logic                    ov_reg, ov_next;   // out beat valid
    logic [1:0]              okind_reg, okind_next;
    logic [VALUE_BITS-1:0]   oval_reg, oval_next;
    logic                    obool_reg, obool_next;
    logic                    olast_reg, olast_next;
    // Output beat registers; they hold still while a beat waits on m_tready.
    logic [1:0]                mkind_reg, mkind_next;
    logic [VALUE_BITS-1:0]     mval_reg, mval_next;
    logic                      mbool_reg, mbool_next;
    logic                      mlast_reg, mlast_next;
    logic [DEPTH_BITS-1:0]     mdepth_reg, mdepth_next;
    logic [NEXT_ADDR_BITS-1:0] maddr_reg, maddr_next;
    err_t                      merr_reg, merr_next;
    logic                      mhalt_reg, mhalt_next;
    logic                    wr_en;
    logic [PTR_BITS-1:0]     wr_addr, rd_addr;
    logic [VALUE_BITS:0]     wr_data, rd_data;
    alu_ctl_t                alu_ctl;
    alu_sts_t                alu_sts;
    logic [VALUE_BITS-1:0]   alu_res;
    logic [4:0]              s_mode;
    logic                    is_bin, need2;
    logic [ADDRESS_BITS-1:0] jmp_ip;

    tsm_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsm_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (alu_ctl),
        .a       (a_reg),
        .b       (b_reg),
        .sts     (alu_sts),
        .result  (alu_res)
    );

    assign s_mode = s_tuser;
    assign jmp_ip = ip_reg + imm_reg[ADDRESS_BITS-1:0];

    always_comb begin
        is_bin = 1'b0;
        unique case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_IEQ,
            OP_BEQ: is_bin = 1'b1;
            default: ;
        endcase
        need2 = is_bin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            ip_reg    <= '0;
            stop_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            ip_reg    <= ip_next;
            stop_reg  <= stop_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
        op_reg     <= op_next;
        imm_reg    <= imm_next;
        b_reg      <= b_next;
        btag_reg   <= btag_next;
        a_reg      <= a_next;
        atag_reg   <= atag_next;
        idx_reg    <= idx_next;
        okind_reg  <= okind_next;
        oval_reg   <= oval_next;
        obool_reg  <= obool_next;
        olast_reg  <= olast_next;
        mkind_reg  <= mkind_next;
        mval_reg   <= mval_next;
        mbool_reg  <= mbool_next;
        mlast_reg  <= mlast_next;
        mdepth_reg <= mdepth_next;
        maddr_reg  <= maddr_next;
        merr_reg   <= merr_next;
        mhalt_reg  <= mhalt_next;
    end

    always_comb begin
        logic [SP_BITS-1:0] need_n;
        logic               need_t;
        err_t               e;
        logic [VALUE_BITS-1:0] res;
        logic                  rtag;

        state_next = state_reg;
        sp_next    = sp_reg;
        ip_next    = ip_reg;
        stop_next  = stop_reg;
        err_next   = err_reg;
        op_next    = op_reg;
        imm_next   = imm_reg;
        b_next     = b_reg;
        btag_next  = btag_reg;
        a_next     = a_reg;
        atag_next  = atag_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        okind_next = okind_reg;
        oval_next  = oval_reg;
        obool_next = obool_reg;
        olast_next = olast_reg;
        mkind_next  = mkind_reg;
        mval_next   = mval_reg;
        mbool_next  = mbool_reg;
        mlast_next  = mlast_reg;
        mdepth_next = mdepth_reg;
        maddr_next  = maddr_reg;
        merr_next   = merr_reg;
        mhalt_next  = mhalt_reg;
        wr_en      = 1'b0;
        wr_addr    = sp_reg[PTR_BITS-1:0];
        wr_data    = '0;
        rd_addr    = '0;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = ALU_MUL;
        s_tready   = 1'b0;
        need_n     = '0;
        need_t     = 1'b0;
        e          = ERR_NONE;
        res        = '0;
        rtag       = 1'b0;

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next  = opcode_t'(s_mode);
                    imm_next = s_tdata[VALUE_BITS-1:0];
                    state_next = ST_RD_TOP;
                end
            end
            ST_RD_TOP: begin
                // Issue read of top of stack (if present).
                rd_addr = PTR_BITS'(sp_reg - 1'b1);
                state_next = ST_RD_WAIT;
                if (stop_reg) begin
                    okind_next = KIND_STEP;
                    oval_next  = '0;
                    obool_next = 1'b0;
                    olast_next = 1'b1;
                    state_next = ST_OUT;
                end else if (op_reg == OP_EXIT) begin
                    stop_next = 1'b1;
                    idx_next  = '0;
                    if (sp_reg == '0) begin
                        okind_next = KIND_EMPTY;
                        oval_next  = '0;
                        obool_next = 1'b0;
                        olast_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            ST_RD_WAIT: begin
                b_next    = rd_data[VALUE_BITS-1:0];
                btag_next = rd_data[VALUE_BITS];
                rd_addr   = PTR_BITS'(sp_reg - 2'd2);
                state_next = need2 ? ST_RD_SEC : ST_EXEC;
            end
            ST_RD_SEC: begin
                a_next    = rd_data[VALUE_BITS-1:0];
                atag_next = rd_data[VALUE_BITS];
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // Fault checks in order: underflow, tag, overflow, zero divisor; an unknown opcode is invalid.
                case (op_reg) inside
                    OP_JUMPF, OP_NOT, OP_BDUP, OP_BDROP, OP_BPRINT: begin
                        need_n = SP_BITS'(1);
                        need_t = 1'b1;
                    end
                    OP_IDUP, OP_IDROP, OP_IPRINT: need_n = SP_BITS'(1);
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_IEQ:
                        need_n = SP_BITS'(2);
                    OP_BEQ: begin
                        need_n = SP_BITS'(2);
                        need_t = 1'b1;
                    end
                    default: ;
                endcase
                if (sp_reg < need_n) begin
                    e = ERR_UNDERFLOW;
                end else if ((need_n != '0 && btag_reg != need_t)
                             || (need_n == SP_BITS'(2) && atag_reg != need_t)) begin
                    e = ERR_TAG;
                end
                case (op_reg) inside
                    OP_JUMP, OP_JUMPF, OP_IDROP, OP_BDROP, OP_IPRINT, OP_BPRINT, OP_NOT,
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_IEQ,
                    OP_BEQ: ;
                    OP_IPUSH, OP_BPUSH, OP_IDUP, OP_BDUP: begin
                        if (e == ERR_NONE && sp_reg >= SP_BITS'(STACK_DEPTH)) begin
                            e = ERR_OVERFLOW;
                        end
                    end
                    default: e = ERR_INVALID;
                endcase
                if (e == ERR_NONE && (op_reg == OP_DIV || op_reg == OP_MOD)
                    && b_reg == '0) begin
                    e = ERR_DIVZERO;
                end
                okind_next = KIND_STEP;
                oval_next  = '0;
                obool_next = 1'b0;
                olast_next = 1'b1;
                if (e != ERR_NONE) begin
                    err_next   = e;
                    stop_next  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    ip_next    = ip_reg + 1'b1;
                    state_next = ST_OUT;
                    unique case (op_reg)
                        OP_JUMP: ip_next = jmp_ip;
                        OP_JUMPF: begin
                            sp_next = sp_reg - 1'b1;
                            if (!b_reg[0]) begin
                                ip_next = jmp_ip;
                            end
                        end
                        OP_IPUSH, OP_BPUSH: begin
                            wr_en   = 1'b1;
                            wr_data = (op_reg == OP_BPUSH)
                                    ? {1'b1, {(VALUE_BITS-1){1'b0}}, imm_reg[0]}
                                    : {1'b0, imm_reg};
                            sp_next = sp_reg + 1'b1;
                        end
                        OP_IDUP, OP_BDUP: begin
                            wr_en   = 1'b1;
                            wr_data = {btag_reg, b_reg};
                            sp_next = sp_reg + 1'b1;
                        end
                        OP_IDROP, OP_BDROP: sp_next = sp_reg - 1'b1;
                        OP_IPRINT, OP_BPRINT: begin
                            sp_next    = sp_reg - 1'b1;
                            okind_next = KIND_PRINT;
                            oval_next  = b_reg;
                            obool_next = btag_reg;
                        end
                        OP_NOT: begin
                            wr_en   = 1'b1;
                            wr_addr = PTR_BITS'(sp_reg - 1'b1);
                            wr_data = {1'b1, b_reg ^ VALUE_BITS'(1)};
                        end
                        OP_MUL, OP_DIV, OP_MOD: begin
                            alu_ctl.start = 1'b1;
                            alu_ctl.op    = (op_reg == OP_MUL) ? ALU_MUL
                                          : (op_reg == OP_DIV) ? ALU_DIV : ALU_MOD;
                            state_next    = ST_ALU_WAIT;
                        end
                        default: begin
                            // Binary ops computed combinationally in the execute state.
                            rtag = 1'b1;
                            unique case (op_reg)
                                OP_ADD: begin
                                    res  = a_reg + b_reg;
                                    rtag = 1'b0;
                                end
                                OP_SUB: begin
                                    res  = a_reg - b_reg;
                                    rtag = 1'b0;
                                end
                                OP_LT:  res = VALUE_BITS'($signed(a_reg) < $signed(b_reg));
                                OP_GT:  res = VALUE_BITS'($signed(a_reg) > $signed(b_reg));
                                default: res = VALUE_BITS'(a_reg == b_reg);
                            endcase
                            wr_en   = 1'b1;
                            wr_addr = PTR_BITS'(sp_reg - 2'd2);
                            wr_data = {rtag, res};
                            sp_next = sp_reg - 1'b1;
                        end
                    endcase
                end
            end
            ST_ALU_WAIT: begin
                if (alu_sts.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                wr_addr    = PTR_BITS'(sp_reg - 2'd2);
                wr_data    = {1'b0, alu_res};
                sp_next    = sp_reg - 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next     = 1'b1;
                    mkind_next  = okind_reg;
                    mval_next   = oval_reg;
                    mbool_next  = obool_reg;
                    mlast_next  = olast_reg;
                    mdepth_next = DEPTH_BITS'(sp_reg);
                    maddr_next  = NEXT_ADDR_BITS'(ip_reg);
                    merr_next   = err_reg;
                    mhalt_next  = stop_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                rd_addr    = idx_reg[PTR_BITS-1:0];
                state_next = ST_DUMP_WAIT;
            end
            ST_DUMP_WAIT: begin
                okind_next = KIND_FINAL;
                oval_next  = rd_data[VALUE_BITS-1:0];
                obool_next = rd_data[VALUE_BITS];
                olast_next = (idx_reg == sp_reg - 1'b1);
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next     = 1'b1;
                    mkind_next  = okind_reg;
                    mval_next   = oval_reg;
                    mbool_next  = obool_reg;
                    mlast_next  = olast_reg;
                    mdepth_next = DEPTH_BITS'(sp_reg);
                    maddr_next  = NEXT_ADDR_BITS'(ip_reg);
                    merr_next   = err_reg;
                    mhalt_next  = stop_reg;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = olast_reg ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = {mbool_reg, mkind_reg};
    assign m_tdata  = {5'd0, mhalt_reg, merr_reg, mdepth_reg, maddr_reg, mval_reg};

    // The stack pointer never exceeds the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_BITS'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // An error always leaves the machine halted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE) |-> stop_reg)
        else $error("error without halt");

    // Input is only taken while idle and with no pending ALU work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !alu_sts.busy)
        else $error("ready while ALU busy");

    // Once halted, the machine stays halted until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |=> stop_reg)
        else $error("halt dropped");
endmodule

FILE: test/tb_typed_stack_machine_executor.sv
// Self-checking testbench for the typed stack-machine executor: directed and random programs.
`timescale 1ns / 100ps

module tb_typed_stack_machine_executor;
    import tsm_pkg::*;

    localparam int MAX_DEPTH  = 64;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic        is_bool;
        logic [15:0] addr;
        logic [6:0]  depth;
        logic [2:0]  err;
        logic        halted;
        logic        last;
    } vm_result_t;

    typedef struct {
        logic [4:0]  mode;
        logic [63:0] imm;
        int          n_results;
        bit          drain;
    } instr_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // [63:0] immediate
    logic [4:0]  s_tuser = '0;   // [4:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // [63:0] out_value, [79:64] next_address,
                                 // [86:80] stack_depth, [89:87] error_code, [90] halted
    logic [2:0]  m_tuser;        // [1:0] out_kind, [2] value_is_bool
    logic        m_tlast;

    typed_stack_machine_executor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Shadow machine state.
    logic [63:0] vm_vals [MAX_DEPTH];
    logic        vm_tags [MAX_DEPTH];
    int          vm_sp;
    logic [15:0] vm_ip;
    logic        vm_halt;
    logic [2:0]  vm_err;

    instr_t      program_q[$];
    vm_result_t  expected_q[$];
    int          total_items;
    int          sent_items = 0;
    int          sent_results = 0;
    int          got_results = 0;
    int          n_mismatch = 0;
    int          idle_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_cnt = 0;
    bit          hold_done = 0;
    int          cur_n = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void emit(logic [1:0] kind, logic [63:0] val, logic isb, logic lst);
        vm_result_t r;
        r.kind = kind;
        r.value = val;
        r.is_bool = isb;
        r.addr = vm_ip;
        r.depth = vm_sp[6:0];
        r.err = vm_err;
        r.halted = vm_halt;
        r.last = lst;
        expected_q.push_back(r);
    endfunction

    function automatic logic [2:0] operand_fault(int n, logic tag);
        if (vm_sp < n)
            return ERR_UNDERFLOW;
        for (int i = 1; i <= n; i++)
            if (vm_tags[vm_sp - i] != tag)
                return ERR_TAG;
        return ERR_NONE;
    endfunction

    function automatic logic [2:0] fault_of(logic [4:0] md);
        logic [2:0] e;
        e = ERR_NONE;
        case (md)
            OP_EXIT, OP_JUMP: e = ERR_NONE;
            OP_JUMPF, OP_NOT, OP_BDROP, OP_BPRINT: e = operand_fault(1, 1'b1);
            OP_IDROP, OP_IPRINT: e = operand_fault(1, 1'b0);
            OP_IPUSH, OP_BPUSH: e = (vm_sp >= MAX_DEPTH) ? ERR_OVERFLOW : ERR_NONE;
            OP_IDUP, OP_BDUP: begin
                e = operand_fault(1, md == OP_BDUP);
                if (e == ERR_NONE && vm_sp >= MAX_DEPTH)
                    e = ERR_OVERFLOW;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_IEQ, OP_BEQ: begin
                e = operand_fault(2, md == OP_BEQ);
                if (e == ERR_NONE && (md == OP_DIV || md == OP_MOD) && vm_vals[vm_sp - 1] == 0)
                    e = ERR_DIVZERO;
            end
            default: e = ERR_INVALID;
        endcase
        return e;
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // Executes one instruction on the shadow machine and queues its results.
    function automatic int execute_instr(logic [4:0] md, logic [63:0] imm);
        logic [2:0]  e;
        logic [15:0] nip;
        logic [63:0] a, b, res;
        logic        rtag;
        bit          printed;
        if (vm_halt) begin
            emit(KIND_STEP, '0, 1'b0, 1'b1);
            return 1;
        end
        e = fault_of(md);
        if (e != ERR_NONE) begin
            vm_err = e;
            vm_halt = 1'b1;
            emit(KIND_STEP, '0, 1'b0, 1'b1);
            return 1;
        end
        if (md == OP_EXIT) begin
            vm_halt = 1'b1;
            if (vm_sp == 0) begin
                emit(KIND_EMPTY, '0, 1'b0, 1'b1);
                return 1;
            end
            for (int k = 0; k < vm_sp; k++)
                emit(KIND_FINAL, vm_vals[k], vm_tags[k], k == vm_sp - 1);
            return vm_sp;
        end
        nip = vm_ip + 16'd1;
        printed = 0;
        res = '0;
        rtag = 1'b0;
        case (md)
            OP_JUMP: nip = vm_ip + imm[15:0];
            OP_JUMPF: begin
                vm_sp--;
                if (!vm_vals[vm_sp][0])
                    nip = vm_ip + imm[15:0];
            end
            OP_IPUSH, OP_BPUSH: begin
                vm_vals[vm_sp] = (md == OP_BPUSH) ? {63'b0, imm[0]} : imm;
                vm_tags[vm_sp] = (md == OP_BPUSH);
                vm_sp++;
            end
            OP_IDUP, OP_BDUP: begin
                vm_vals[vm_sp] = vm_vals[vm_sp - 1];
                vm_tags[vm_sp] = (md == OP_BDUP);
                vm_sp++;
            end
            OP_IDROP, OP_BDROP: vm_sp--;
            OP_IPRINT, OP_BPRINT: begin
                vm_sp--;
                res = vm_vals[vm_sp];
                rtag = (md == OP_BPRINT);
                printed = 1;
            end
            OP_NOT: vm_vals[vm_sp - 1][0] = ~vm_vals[vm_sp - 1][0];
            default: begin
                b = vm_vals[vm_sp - 1];
                a = vm_vals[vm_sp - 2];
                rtag = 1'b1;
                case (md)
                    OP_ADD: begin res = a + b; rtag = 1'b0; end
                    OP_SUB: begin res = a - b; rtag = 1'b0; end
                    OP_MUL: begin res = a * b; rtag = 1'b0; end
                    OP_DIV: begin
                        res = magnitude(a) / magnitude(b);
                        if (a[63] ^ b[63])
                            res = -res;
                        rtag = 1'b0;
                    end
                    OP_MOD: begin
                        res = magnitude(a) % magnitude(b);
                        if (a[63])
                            res = -res;
                        rtag = 1'b0;
                    end
                    OP_LT: res = {63'b0, $signed(a) < $signed(b)};
                    OP_GT: res = {63'b0, $signed(a) > $signed(b)};
                    default: res = {63'b0, a == b};
                endcase
                vm_sp -= 2;
                vm_vals[vm_sp] = res;
                vm_tags[vm_sp] = rtag;
                vm_sp++;
                printed = 0;
                res = '0;
                rtag = 1'b0;
            end
        endcase
        vm_ip = nip;
        if (printed)
            emit(KIND_PRINT, res, rtag, 1'b1);
        else
            emit(KIND_STEP, '0, 1'b0, 1'b1);
        return 1;
    endfunction

    function automatic void add_instr(logic [4:0] md, logic [63:0] imm, bit drain = 0);
        instr_t it;
        it.mode = md;
        it.imm = imm;
        it.drain = drain;
        it.n_results = execute_instr(md, imm);
        program_q.push_back(it);
    endfunction

    function automatic logic [63:0] random_imm();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return 64'h7fff_ffff_ffff_ffff;
            3: return 64'h8000_0000_0000_0000;
            4: return 64'($signed($urandom_range(0, 20)) - 10);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Builds the whole program up front; the shadow machine picks only legal steps
    // until the halting instruction, which either exits or faults; halted steps follow it.
    initial begin
        logic [4:0] md;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            vm_vals[i] = '0;
            vm_tags[i] = 1'b0;
        end
        vm_sp = 0;
        vm_ip = '0;
        vm_halt = 1'b0;
        vm_err = ERR_NONE;

        add_instr(OP_IPUSH, 64'h7fff_ffff_ffff_ffff);
        add_instr(OP_IPUSH, 64'd1);
        add_instr(OP_ADD, random_imm());
        add_instr(OP_IPUSH, '1);
        add_instr(OP_DIV, random_imm());
        add_instr(OP_IDUP, random_imm());
        add_instr(OP_IPUSH, '1);
        add_instr(OP_MOD, random_imm());
        add_instr(OP_ADD, random_imm());
        add_instr(OP_IPUSH, -64'sd7);
        add_instr(OP_IPUSH, 64'd2);
        add_instr(OP_MOD, random_imm());
        add_instr(OP_MUL, random_imm());
        add_instr(OP_IPUSH, 64'd3);
        add_instr(OP_LT, random_imm());
        add_instr(OP_BPUSH, -64'sd2);
        add_instr(OP_BEQ, random_imm());
        add_instr(OP_NOT, random_imm());
        add_instr(OP_BDUP, random_imm());
        add_instr(OP_BPRINT, random_imm());
        add_instr(OP_JUMPF, 64'd5);
        add_instr(OP_BPUSH, 64'd0);
        add_instr(OP_JUMPF, -64'sd3);
        add_instr(OP_JUMP, 64'h8000_0000_0000_0000);
        add_instr(OP_IPUSH, '1);
        add_instr(OP_IPUSH, 64'd9);
        add_instr(OP_SUB, random_imm());
        add_instr(OP_IPRINT, random_imm());

        for (int i = 0; i < 275; i++) begin
            if (vm_sp < MAX_DEPTH && $urandom_range(0, 2) == 0) begin
                md = $urandom_range(0, 1) ? OP_IPUSH : OP_BPUSH;
            end else begin
                do
                    md = 5'($urandom_range(OP_JUMP, OP_BPRINT));
                while (fault_of(md) != ERR_NONE);
            end
            add_instr(md, random_imm(), i == 130);
        end

        if ($urandom_range(0, 1)) begin
            while (vm_sp < MAX_DEPTH && $urandom_range(0, 3) != 0)
                add_instr($urandom_range(0, 1) ? OP_IPUSH : OP_BPUSH, random_imm());
            add_instr(OP_EXIT, random_imm());
        end else begin
            do
                md = 5'($urandom_range(0, 31));
            while (fault_of(md) == ERR_NONE);
            add_instr(md, random_imm());
        end
        // The machine is halted now; these steps must leave its state alone.
        for (int i = 0; i < 5; i++)
            add_instr(5'($urandom_range(0, 31)), random_imm());
        total_items = program_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait (program_q.size() == 0 && !s_tvalid && got_results == sent_results);
        repeat (200) @(posedge aclk);
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge aclk) begin
        int sr;
        instr_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            sr = sent_results + (s_tvalid ? cur_n : 0);
            if (s_tvalid) begin
                sent_results <= sr;
                sent_items <= sent_items + 1;
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (program_q.size() == 0 ||
                         (program_q[0].drain && got_results != sr)) begin
                s_tvalid <= 1'b0;
            end else begin
                it = program_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.imm;
                s_tuser <= it.mode;
                cur_n <= it.n_results;
                if (sent_items < total_items - 40 && $urandom_range(0, 4) == 0)
                    in_gap <= $urandom_range(1, 17);
            end
        end
    end

    always @(posedge aclk) begin
        vm_result_t act, exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                act.kind = m_tuser[1:0];
                act.is_bool = m_tuser[2];
                act.value = m_tdata[63:0];
                act.addr = m_tdata[79:64];
                act.depth = m_tdata[86:80];
                act.err = m_tdata[89:87];
                act.halted = m_tdata[90];
                act.last = m_tlast;
                got_results <= got_results + 1;
                if (expected_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat: %p", act);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (act !== exp_r) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("result mismatch: expected %p, actual %p", exp_r, act);
                    end
                end
            end
            // One long hold-off lets the input side back up behind a stalled output.
            if (got_results == 40 && !hold_done) begin
                hold_done <= 1;
                hold_cnt <= HOLD_LEN;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sent_items < total_items - 40 && $urandom_range(0, 5) == 0)
                    out_gap <= $urandom_range(1, 17);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: typed_stack_machine_executor.f
sv/tsm_pkg.sv
sv/tsm_ram.sv
sv/tsm_alu.sv
sv/typed_stack_machine_executor.sv
test/tb_typed_stack_machine_executor.sv
